// ===== hw/rtl/mm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mm_pkg;
  localparam int MAX_DIM_DEF = 8;
  localparam int ELEM_W = 16;
  localparam int SUM_W = 35;
  localparam int DIM_W = 4;
  localparam int IDX_W = 3;
  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_INNER_LEN = 2'd1;
  localparam logic [1:0] REG_COLS_B = 2'd2;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] mx);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = {{(DIM_W-1){1'b0}}, 1'b1};
    else if (v > mx) r = mx;
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/mm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One MAC cell: multiplies the shared a by its own b and accumulates.
// On shift it takes its right neighbor's sum, so sums leave from cell 0.
module mm_cell (
  input  wire logic                               clk,
  input  wire logic                               clr,
  input  wire logic                               mac_en,
  input  wire logic                               shift_en,
  input  wire logic signed [mm_pkg::ELEM_W-1:0]   a_in,
  input  wire logic signed [mm_pkg::ELEM_W-1:0]   b_in,
  input  wire logic signed [mm_pkg::SUM_W-1:0]    sum_in,
  output logic signed [mm_pkg::SUM_W-1:0]         sum_out
);
  logic signed [2*mm_pkg::ELEM_W-1:0] prod_r;
  logic prod_v_r;
  logic signed [mm_pkg::SUM_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    prod_r <= a_in * b_in;
    prod_v_r <= mac_en;
    if (clr) begin
      acc_r <= '0;
    end else if (shift_en) begin
      acc_r <= sum_in;
    end else if (prod_v_r) begin
      acc_r <= acc_r + mm_pkg::SUM_W'(prod_r);
    end
  end

  assign sum_out = acc_r;
endmodule
`default_nettype wire

// ===== hw/rtl/matrix_multiply.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Load: one element per cycle while busy is low; config writes only while idle.
// After the last B element, a row of MAX_DIM MAC cells computes one result
// row, then shifts cols_b sums out one per cycle, for each row of A in turn.
// Busy stays high until the last sum is shifted out. Results cannot be stalled.
// Synchronous active-low reset: sizes MAX_DIM, load count zero; stores not cleared.
module matrix_multiply #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [mm_pkg::ELEM_W-1:0]  in_element,
  output logic                                   out_valid,
  output logic signed [mm_pkg::SUM_W-1:0]        out_sum_value,
  output logic [mm_pkg::IDX_W-1:0]               out_row,
  output logic [mm_pkg::IDX_W-1:0]               out_col,
  output logic                                   out_last_out,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [mm_pkg::DIM_W-1:0]          cfg_data
);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W = AW + 2;
  localparam logic [mm_pkg::DIM_W-1:0] MXD = mm_pkg::DIM_W'(MAX_DIM);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_MAC = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  logic [mm_pkg::DIM_W-1:0] rows_r, inner_r, cols_r;
  logic [1:0] st_r;
  logic [CNT_W-1:0] load_r;
  logic [mm_pkg::ELEM_W-1:0] a_mem [DEPTH];

  logic [mm_pkg::DIM_W-1:0] nr, nk, nc;
  logic [CNT_W-1:0] na, nab;
  assign nr = mm_pkg::eff_dim(rows_r, MXD);
  assign nk = mm_pkg::eff_dim(inner_r, MXD);
  assign nc = mm_pkg::eff_dim(cols_r, MXD);
  assign na = CNT_W'(nr * nk);
  assign nab = na + CNT_W'(nk * nc);

  logic acc;
  logic cfg_wr, cfg_hit;
  assign busy = (st_r != ST_LOAD);
  assign acc = start && !busy;
  assign cfg_ready = !busy && !start;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign cfg_hit = cfg_wr && (cfg_index == mm_pkg::REG_ROWS_A ||
                              cfg_index == mm_pkg::REG_INNER_LEN ||
                              cfg_index == mm_pkg::REG_COLS_B);

  // compute sequencing
  logic [CW-1:0] row_r, col_r;
  logic [CW-1:0] bk_r, bc_r;
  logic [mm_pkg::DIM_W-1:0] k_r;
  logic [2:0] drain_r;
  logic [mm_pkg::DIM_W-1:0] ocnt_r;
  logic [AW-1:0] a_base_r;
  logic signed [mm_pkg::ELEM_W-1:0] a_rd_r;
  logic signed [mm_pkg::ELEM_W-1:0] b_rd_r [MAX_DIM];
  logic feed_r;
  logic clr, shift_en;

  always_ff @(posedge clk) begin
    if (acc && (load_r < na)) a_mem[AW'(load_r)] <= in_element;
    a_rd_r <= a_mem[AW'(a_base_r + AW'(k_r))];
  end

  // B is banked by column; each bank holds one column, read at row k
  genvar g;
  generate
    for (g = 0; g < MAX_DIM; g++) begin : g_brd
      logic [mm_pkg::ELEM_W-1:0] b_bank [MAX_DIM];
      always_ff @(posedge clk) begin
        if (acc && (load_r >= na) && (bc_r == CW'(g))) b_bank[bk_r] <= in_element;
        b_rd_r[g] <= b_bank[CW'(k_r)];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= MXD; inner_r <= MXD; cols_r <= MXD;
      st_r <= ST_LOAD; load_r <= '0; bk_r <= '0; bc_r <= '0;
      k_r <= '0; row_r <= '0; col_r <= '0; drain_r <= '0; ocnt_r <= '0;
      a_base_r <= '0; feed_r <= 1'b0;
    end else begin
      feed_r <= (st_r == ST_MAC) && (k_r < nk);
      if (cfg_hit) begin
        case (cfg_index)
          mm_pkg::REG_ROWS_A:    rows_r <= cfg_data;
          mm_pkg::REG_INNER_LEN: inner_r <= cfg_data;
          mm_pkg::REG_COLS_B:    cols_r <= cfg_data;
          default: ;
        endcase
        load_r <= '0; bk_r <= '0; bc_r <= '0;
      end else begin
        case (st_r)
          ST_LOAD: begin
            if (acc) begin
              if (load_r + 1'b1 >= nab) begin
                load_r <= '0; st_r <= ST_MAC; k_r <= '0; row_r <= '0;
                a_base_r <= '0; drain_r <= '0; bk_r <= '0; bc_r <= '0;
              end else begin
                load_r <= load_r + 1'b1;
                if (load_r >= na) begin
                  if (mm_pkg::DIM_W'(bc_r) + 1'b1 >= nc) begin
                    bc_r <= '0; bk_r <= bk_r + 1'b1;
                  end else begin
                    bc_r <= bc_r + 1'b1;
                  end
                end
              end
            end
          end
          ST_MAC: begin
            if (k_r < nk) begin
              k_r <= k_r + 1'b1;
            end else if (drain_r != 3'd3) begin
              drain_r <= drain_r + 1'b1;
            end else begin
              st_r <= ST_OUT; ocnt_r <= '0; col_r <= '0;
            end
          end
          ST_OUT: begin
            col_r <= col_r + 1'b1;
            ocnt_r <= ocnt_r + 1'b1;
            if (ocnt_r + 1'b1 >= nc) begin
              if (mm_pkg::DIM_W'(row_r) + 1'b1 >= nr) begin
                st_r <= ST_LOAD;
              end else begin
                row_r <= row_r + 1'b1; st_r <= ST_MAC; k_r <= '0; drain_r <= '0;
                a_base_r <= a_base_r + AW'(nk);
              end
            end
          end
          default: st_r <= ST_LOAD;
        endcase
      end
    end
  end

  assign clr = (st_r == ST_MAC) && (k_r == '0) && (drain_r == '0);
  assign shift_en = (st_r == ST_OUT);

  // chain: each cell hands its sum to its left neighbor on shift
  logic signed [mm_pkg::SUM_W-1:0] s_ch [MAX_DIM+1];
  assign s_ch[MAX_DIM] = '0;

  generate
    for (g = 0; g < MAX_DIM; g++) begin : g_cell
      mm_cell u_cell (
        .clk(clk), .clr(clr), .mac_en(feed_r), .shift_en(shift_en),
        .a_in(a_rd_r), .b_in(b_rd_r[g]), .sum_in(s_ch[g+1]),
        .sum_out(s_ch[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= shift_en;
    end
    out_sum_value <= s_ch[0];
    out_row <= mm_pkg::IDX_W'(row_r);
    out_col <= mm_pkg::IDX_W'(col_r);
    out_last_out <= (ocnt_r + 1'b1 >= nc) && (mm_pkg::DIM_W'(row_r) + 1'b1 >= nr);
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_last_out
);
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_out && out_valid |=> !out_valid) else $error("result after last");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result while idle");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !$past(busy) |-> !out_valid) else $error("stray result");
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid) else $error("result after load beat");
endmodule
bind matrix_multiply mm_checker u_chk (.clk(clk), .rst_n(rst_n), .start(start),
  .busy(busy), .out_valid(out_valid), .out_last_out(out_last_out));
`default_nettype wire
